// File: src/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the beam top-k selector
// Sequencer states, result kinds, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

  localparam int unsigned DefMaxBeam = 64;
  // probe table size: must stay 2^k - 1, the probe start folds the hash in k-bit chunks
  localparam int unsigned TableSize  = 1023;

  localparam int unsigned ActW  = 32;
  localparam int unsigned CostW = 32;
  localparam int unsigned HashW = 64;
  localparam int unsigned ParW  = 6;
  localparam int unsigned BwW   = 7;

  localparam logic [BwW-1:0] BwReset = 7'd64;

  localparam logic [1:0] KIND_FIN   = 2'd0;
  localparam logic [1:0] KIND_KEPT  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] CFG_BEAM_WIDTH = 2'd0;
  localparam logic [1:0] CFG_DEDUP      = 2'd1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CLR  = 9'b000000010,
    ST_MOD  = 9'b000000100,
    ST_SCAN = 9'b000001000,
    ST_PRD  = 9'b000010000,
    ST_PCHK = 9'b000100000,
    ST_SCHK = 9'b001000000,
    ST_INS  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

// File: src/beam_top_k_selector_dedup_unit.sv
// ----------------------------------------------------------------------------
// beam_top_k_selector_dedup_unit: beam top-k selector with hash dedup
// Keeps the lowest-cost candidates, merges equal hashes, forwards finished
// candidates and emits the kept beam on flush.
// ----------------------------------------------------------------------------
// One sequencer drives a single slot memory port, a single probe-table port
// and a chunked hash-modulo unit: the table size is 2^10 - 1, so the probe
// start is the sum of the 10-bit chunks of the hash modulo the table size,
// one chunk per cycle with a compare and subtract. A finished push gives its
// word on the cycle after acceptance. An unfinished push runs the worst-slot
// scan when the beam is full, the hash remainder when dedup is on, the
// probes, and then the update. A flush scans the kept slots and outputs them
// (one word per cycle), or gives one empty word if none are kept, then runs a
// table clearing pass over all TABLE_SIZE entries. After reset the same
// clearing pass runs with busy_o high. Configuration words are taken only
// while idle and no start is pending. Results cannot be held off: each word
// is shown for exactly one cycle.
`default_nettype none

module beam_top_k_selector_dedup_unit #(
  parameter int unsigned MAX_BEAM = bts_pkg::DefMaxBeam
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic                             func_i,
  input  wire logic [bts_pkg::ActW-1:0]         action_i,
  input  wire logic signed [bts_pkg::CostW-1:0] cost_i,
  input  wire logic [bts_pkg::HashW-1:0]        hash_i,
  input  wire logic [bts_pkg::ParW-1:0]         parent_i,
  input  wire logic                             finished_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [1:0]                       cfg_index_i,
  input  wire logic [bts_pkg::BwW-1:0]          cfg_data_i,
  output logic                                  res_valid_o,
  output logic [1:0]                            kind_o,
  output logic [bts_pkg::ActW-1:0]              action_res_o,
  output logic signed [bts_pkg::CostW-1:0]      cost_res_o,
  output logic [bts_pkg::HashW-1:0]             hash_res_o,
  output logic [bts_pkg::ParW-1:0]              parent_res_o,
  output logic                                  is_best_o,
  output logic                                  last_o,
  output logic                                  overflow_o
);
  import bts_pkg::*;

  localparam int unsigned TABLE_SIZE = TableSize;
  localparam int unsigned SW = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;
  localparam int unsigned KW = $clog2(MAX_BEAM + 1);
  localparam int unsigned TW = $clog2(TABLE_SIZE);
  localparam int unsigned PW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned NChunks = (HashW + TW - 1) / TW;

  state_e state_q;

  logic [BwW-1:0] bw_cfg_q;
  logic           dedup_q;
  logic [KW-1:0]  kept_q;
  logic           beam_full_q;
  logic           ovf_q;

  // candidate held during a push
  logic [ActW-1:0]         c_act_q;
  logic signed [CostW-1:0] c_cost_q;
  logic [HashW-1:0]        c_hash_q;
  logic [ParW-1:0]         c_par_q;
  logic                    full_q;
  logic                    mode_best_q;

  // scan / emit bookkeeping
  logic [KW-1:0]           idx_q;
  logic                    pend_q;
  logic [KW-1:0]           pidx_q;
  logic signed [CostW-1:0] ext_cost_q;
  logic [SW-1:0]           ext_idx_q;

  // remainder unit and probing
  logic [TW-1:0]    rem_q;
  logic [2:0]       bcnt_q;
  logic [HashW-1:0] hsh_q;
  logic [TW-1:0]    pos_q;
  logic [PW-1:0]    probes_q;
  logic [TW-1:0]    clr_q;
  logic [SW-1:0]    hit_slot_q;

  // memories
  logic [ActW-1:0]  slot_act_m  [MAX_BEAM];
  logic [CostW-1:0] slot_cost_m [MAX_BEAM];
  logic [HashW-1:0] slot_hash_m [MAX_BEAM];
  logic [ParW-1:0]  slot_par_m  [MAX_BEAM];
  logic [ActW-1:0]         rd_act_q;
  logic signed [CostW-1:0] rd_cost_q;
  logic [HashW-1:0]        rd_hash_q;
  logic [ParW-1:0]         rd_par_q;

  logic             tab_vld_m  [TABLE_SIZE];
  logic [HashW-1:0] tab_key_m  [TABLE_SIZE];
  logic [SW-1:0]    tab_slot_m [TABLE_SIZE];
  logic             tab_vld_rd_q;
  logic [HashW-1:0] tab_key_rd_q;
  logic [SW-1:0]    tab_slot_rd_q;

  logic           accept;
  logic [BwW-1:0] eff_bw;
  logic           full_now;
  logic [SW-1:0]  rd_addr;
  logic           slot_we;
  logic [SW-1:0]  slot_wa;
  logic           tab_we;
  logic [TW-1:0]  tab_wa;
  logic [TW:0]    mod_t;
  logic [TW:0]    mod_n;
  logic [TW-1:0]  pos_inc;
  logic           scan_done;
  logic           better;
  logic [SW-1:0]  ins_j;
  logic           ins_ok;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o && !start_i;

  always_comb begin
    if (bw_cfg_q == '0) begin
      eff_bw = BwW'(1);
    end else if (bw_cfg_q > BwW'(MAX_BEAM)) begin
      eff_bw = BwW'(MAX_BEAM);
    end else begin
      eff_bw = bw_cfg_q;
    end
  end

  assign full_now = beam_full_q || (BwW'(kept_q) >= eff_bw);

  // 2^TW is 1 modulo the table size: add one chunk per cycle, fold once
  assign mod_t   = {1'b0, rem_q} + {1'b0, hsh_q[TW-1:0]};
  assign mod_n   = (mod_t >= (TW+1)'(TABLE_SIZE)) ? mod_t - (TW+1)'(TABLE_SIZE) : mod_t;
  assign pos_inc = (pos_q == TW'(TABLE_SIZE - 1)) ? '0 : pos_q + 1'b1;

  assign scan_done = !pend_q && (idx_q == kept_q);
  assign better    = mode_best_q ? (rd_cost_q < ext_cost_q) : (rd_cost_q > ext_cost_q);

  assign rd_addr = (state_q == ST_PCHK) ? tab_slot_rd_q : idx_q[SW-1:0];

  assign ins_ok = full_q || (kept_q < KW'(MAX_BEAM));
  assign ins_j  = full_q ? ext_idx_q : kept_q[SW-1:0];

  always_comb begin
    slot_we = 1'b0;
    slot_wa = ins_j;
    if (state_q == ST_INS) begin
      slot_we = ins_ok;
    end else if (state_q == ST_SCHK) begin
      slot_wa = hit_slot_q;
      slot_we = (KW'(hit_slot_q) < kept_q) && (rd_hash_q == c_hash_q) &&
                (c_cost_q < rd_cost_q);
    end
  end

  assign tab_we = (state_q == ST_CLR) || ((state_q == ST_INS) && ins_ok && dedup_q);
  assign tab_wa = (state_q == ST_CLR) ? clr_q : pos_q;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_act_m[slot_wa]  <= c_act_q;
      slot_cost_m[slot_wa] <= c_cost_q;
      slot_hash_m[slot_wa] <= c_hash_q;
      slot_par_m[slot_wa]  <= c_par_q;
    end
    rd_act_q  <= slot_act_m[rd_addr];
    rd_cost_q <= slot_cost_m[rd_addr];
    rd_hash_q <= slot_hash_m[rd_addr];
    rd_par_q  <= slot_par_m[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_vld_m[tab_wa]  <= (state_q != ST_CLR);
      tab_key_m[tab_wa]  <= c_hash_q;
      tab_slot_m[tab_wa] <= ins_j;
    end
    tab_vld_rd_q  <= tab_vld_m[pos_q];
    tab_key_rd_q  <= tab_key_m[pos_q];
    tab_slot_rd_q <= tab_slot_m[pos_q];
  end

  // payload of the candidate and of the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_act_q  <= action_i;
      c_cost_q <= cost_i;
      c_hash_q <= hash_i;
      c_par_q  <= parent_i;
      hsh_q    <= hash_i;
    end else if (state_q == ST_MOD) begin
      hsh_q <= hsh_q >> TW;
    end
    if (accept && func_i) begin
      kind_o       <= KIND_EMPTY;
      action_res_o <= '0;
      cost_res_o   <= '0;
      hash_res_o   <= '0;
      parent_res_o <= '0;
      is_best_o    <= 1'b0;
      last_o       <= 1'b1;
      overflow_o   <= ovf_q;
    end else if (accept) begin
      kind_o       <= KIND_FIN;
      action_res_o <= action_i;
      cost_res_o   <= cost_i;
      hash_res_o   <= hash_i;
      parent_res_o <= parent_i;
      is_best_o    <= 1'b0;
      last_o       <= 1'b1;
      overflow_o   <= ovf_q;
    end else if (state_q == ST_EMIT && pend_q) begin
      kind_o       <= KIND_KEPT;
      action_res_o <= rd_act_q;
      cost_res_o   <= rd_cost_q;
      hash_res_o   <= rd_hash_q;
      parent_res_o <= rd_par_q;
      is_best_o    <= (pidx_q[SW-1:0] == ext_idx_q);
      last_o       <= (pidx_q + 1'b1 == kept_q);
      overflow_o   <= ovf_q;
    end
    if (state_q == ST_SCAN && pend_q && (pidx_q == '0 || better)) begin
      ext_cost_q <= rd_cost_q;
      ext_idx_q  <= pidx_q[SW-1:0];
    end
    if (state_q == ST_PCHK) begin
      hit_slot_q <= tab_slot_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      bw_cfg_q    <= BwReset;
      dedup_q     <= 1'b1;
      kept_q      <= '0;
      beam_full_q <= 1'b0;
      ovf_q       <= 1'b0;
      full_q      <= 1'b0;
      mode_best_q <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      rem_q       <= '0;
      bcnt_q      <= '0;
      pos_q       <= '0;
      probes_q    <= '0;
      clr_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_BEAM_WIDTH) begin
          bw_cfg_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_DEDUP) begin
          dedup_q <= cfg_data_i[0];
        end
      end

      // scan and emit share one issue counter, one word per cycle
      if (state_q == ST_SCAN || state_q == ST_EMIT) begin
        pidx_q <= idx_q;
        if (idx_q != kept_q) begin
          idx_q  <= idx_q + 1'b1;
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q    <= '0;
            pend_q   <= 1'b0;
            rem_q    <= '0;
            bcnt_q   <= 3'(NChunks - 1);
            probes_q <= '0;
            full_q   <= full_now;
            if (func_i) begin
              mode_best_q <= 1'b1;
              if (kept_q == '0) begin
                res_valid_o <= 1'b1;
                clr_q       <= '0;
                state_q     <= ST_CLR;
              end else begin
                state_q <= ST_SCAN;
              end
            end else if (finished_i) begin
              res_valid_o <= 1'b1;
            end else begin
              mode_best_q <= 1'b0;
              if (full_now) begin
                state_q <= ST_SCAN;
              end else if (dedup_q) begin
                state_q <= ST_MOD;
              end else begin
                state_q <= ST_INS;
              end
            end
          end
        end
        ST_CLR: begin
          // clear the generation, then sweep the probe table
          kept_q      <= '0;
          beam_full_q <= 1'b0;
          ovf_q       <= 1'b0;
          if (clr_q == TW'(TABLE_SIZE - 1)) begin
            clr_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            idx_q <= '0;
            if (mode_best_q) begin
              state_q <= ST_EMIT;
            end else if (c_cost_q >= ext_cost_q) begin
              state_q <= ST_IDLE;
            end else if (dedup_q) begin
              state_q <= ST_MOD;
            end else begin
              state_q <= ST_INS;
            end
          end
        end
        ST_MOD: begin
          rem_q  <= mod_n[TW-1:0];
          bcnt_q <= bcnt_q - 1'b1;
          if (bcnt_q == '0) begin
            pos_q   <= mod_n[TW-1:0];
            state_q <= ST_PRD;
          end
        end
        ST_PRD: begin
          state_q <= ST_PCHK;
        end
        ST_PCHK: begin
          if (tab_vld_rd_q && tab_key_rd_q == c_hash_q) begin
            state_q <= ST_SCHK;
          end else if (tab_vld_rd_q) begin
            if (probes_q == PW'(TABLE_SIZE - 1)) begin
              ovf_q   <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              probes_q <= probes_q + 1'b1;
              pos_q    <= pos_inc;
              state_q  <= ST_PRD;
            end
          end else begin
            state_q <= ST_INS;
          end
        end
        ST_SCHK: begin
          // a live mapping ends the push; a stale one is reused
          if ((KW'(hit_slot_q) < kept_q) && (rd_hash_q == c_hash_q)) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_INS;
          end
        end
        ST_INS: begin
          if (!full_q && ins_ok) begin
            kept_q <= kept_q + 1'b1;
            if (BwW'(kept_q + 1'b1) >= eff_bw) begin
              beam_full_q <= 1'b1;
            end
          end
          state_q <= ST_IDLE;
        end
        ST_EMIT: begin
          if (pend_q) begin
            res_valid_o <= 1'b1;
          end
          if (scan_done && idx_q != '0) begin
            clr_q   <= '0;
            state_q <= ST_CLR;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  kept_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KW'(MAX_BEAM))
    else $error("kept count beyond slot store");

  res_source_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == ST_IDLE) || ($past(state_q) == ST_EMIT))
    else $error("result word from unexpected state");

  ovf_rise_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(state_q) == ST_PCHK)
    else $error("overflow set outside probing");

  kept_res_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && kind_o == KIND_KEPT) |-> $past(state_q) == ST_EMIT)
    else $error("kept word outside flush");

endmodule

`default_nettype wire

// File: tb/sv/beam_top_k_selector_dedup_unit_tb.sv
// ----------------------------------------------------------------------------
// beam_top_k_selector_dedup_unit_tb: self-checking bench of the beam selector
// Drives pushes and flushes with random gaps, mirrors the beam, hash table and
// registers in a scoreboard, and checks every result word as it appears.
// ----------------------------------------------------------------------------
module beam_top_k_selector_dedup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bts_pkg::*;

  localparam int NSlots     = 64;
  localparam int NEntries   = 1023;
  localparam int DrainWait  = 1200;
  localparam int StallLimit = 20000;

  typedef struct {
    logic              func;
    logic [31:0]       action;
    logic signed [31:0] cost;
    logic [63:0]       hash;
    logic [5:0]        parent;
    logic              finished;
  } cand_t;

  typedef struct {
    logic [1:0]         kind;
    logic [31:0]        action;
    logic signed [31:0] cost;
    logic [63:0]        hash;
    logic [5:0]         parent;
    logic               best;
    logic               last;
    logic               ovf;
  } word_t;

  class beam_scoreboard;
    logic [31:0]        s_act[NSlots];
    logic signed [31:0] s_cost[NSlots];
    logic [63:0]        s_hash[NSlots];
    logic [5:0]         s_par[NSlots];
    int                 kept;
    bit                 full_flag;
    bit                 ovf;
    bit                 t_valid[NEntries];
    logic [63:0]        t_key[NEntries];
    int                 t_slot[NEntries];
    int                 width_reg;
    bit                 dedup_on;
    word_t              pending_words[$];
    int                 errors;

    function new();
      kept = 0;
      full_flag = 0;
      ovf = 0;
      foreach (t_valid[i]) t_valid[i] = 0;
      width_reg = 64;
      dedup_on = 1;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      if (idx == CFG_BEAM_WIDTH) width_reg = int'(val);
      else if (idx == CFG_DEDUP) dedup_on = val[0];
    endfunction

    function void add_word(logic [1:0] kind, logic [31:0] a, logic signed [31:0] c,
                           logic [63:0] h, logic [5:0] p, logic b, logic l);
      word_t w;
      w.kind = kind; w.action = a; w.cost = c; w.hash = h; w.parent = p;
      w.best = b; w.last = l; w.ovf = ovf;
      pending_words = {pending_words, w};
    endfunction

    function void note_item(cand_t it);
      int bw, worst, best, pos, probes, j;
      bit full, hit;
      bw = (width_reg < 1) ? 1 : (width_reg > NSlots) ? NSlots : width_reg;
      if (it.func) begin
        if (kept == 0) begin
          add_word(KIND_EMPTY, '0, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          best = 0;
          for (int i = 1; i < kept; i++) if (s_cost[i] < s_cost[best]) best = i;
          for (int i = 0; i < kept; i++)
            add_word(KIND_KEPT, s_act[i], s_cost[i], s_hash[i], s_par[i], i == best,
                     i + 1 == kept);
        end
        kept = 0; full_flag = 0; ovf = 0;
        foreach (t_valid[i]) t_valid[i] = 0;
        return;
      end
      if (it.finished) begin
        add_word(KIND_FIN, it.action, it.cost, it.hash, it.parent, 1'b0, 1'b1);
        return;
      end
      full = full_flag || kept >= bw;
      worst = 0;
      pos = 0;
      if (full && kept > 0) begin
        for (int i = 1; i < kept; i++) if (s_cost[i] > s_cost[worst]) worst = i;
        if (it.cost >= s_cost[worst]) return;
      end
      if (dedup_on) begin
        probes = 0;
        hit = 0;
        pos = int'(it.hash % 64'd1023);
        while (probes < NEntries && t_valid[pos]) begin
          if (t_key[pos] == it.hash) begin
            hit = 1;
            break;
          end
          pos = (pos + 1 >= NEntries) ? 0 : pos + 1;
          probes++;
        end
        if (!hit && probes >= NEntries) begin
          ovf = 1;
          return;
        end
        if (hit) begin
          j = t_slot[pos];
          if (j < kept && s_hash[j] == it.hash) begin
            if (it.cost < s_cost[j]) begin
              s_act[j] = it.action; s_cost[j] = it.cost;
              s_hash[j] = it.hash; s_par[j] = it.parent;
            end
            return;
          end
        end
      end
      if (full && kept > 0) begin
        j = worst;
      end else begin
        if (kept >= NSlots) return;
        j = kept;
        kept++;
        if (kept >= bw) full_flag = 1;
      end
      if (dedup_on) begin
        t_valid[pos] = 1; t_key[pos] = it.hash; t_slot[pos] = j;
      end
      s_act[j] = it.action; s_cost[j] = it.cost; s_hash[j] = it.hash; s_par[j] = it.parent;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, want %h", what, got, want);
      errors++;
    endtask

    task check_word(word_t w);
      word_t e;
      if (pending_words.size() == 0) begin
        report("unexpected word kind", 64'(w.kind), '0);
        return;
      end
      e = pending_words.pop_front();
      if (w.kind !== e.kind) report("kind", 64'(w.kind), 64'(e.kind));
      if (w.action !== e.action) report("action", 64'(w.action), 64'(e.action));
      if (w.cost !== e.cost) report("cost", 64'(w.cost), 64'(e.cost));
      if (w.hash !== e.hash) report("hash", w.hash, e.hash);
      if (w.parent !== e.parent) report("parent", 64'(w.parent), 64'(e.parent));
      if (w.best !== e.best) report("is_best", 64'(w.best), 64'(e.best));
      if (w.last !== e.last) report("last", 64'(w.last), 64'(e.last));
      if (w.ovf !== e.ovf) report("overflow", 64'(w.ovf), 64'(e.ovf));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               func_i = 1'b0;
  logic [31:0]        action_i = '0;
  logic signed [31:0] cost_i = '0;
  logic [63:0]        hash_i = '0;
  logic [5:0]         parent_i = '0;
  logic               finished_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [6:0]         cfg_data_i = '0;
  logic               res_valid_o;
  logic [1:0]         kind_o;
  logic [31:0]        action_res_o;
  logic signed [31:0] cost_res_o;
  logic [63:0]        hash_res_o;
  logic [5:0]         parent_res_o;
  logic               is_best_o;
  logic               last_o;
  logic               overflow_o;

  beam_scoreboard sb = new();
  int  stall_cycles = 0;
  int  pushes_sent = 0;
  bit  no_gaps = 0;

  always #4 clk_i = ~clk_i;

  beam_top_k_selector_dedup_unit u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .action_i, .cost_i, .hash_i,
    .parent_i, .finished_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .res_valid_o, .kind_o, .action_res_o, .cost_res_o, .hash_res_o, .parent_res_o,
    .is_best_o, .last_o, .overflow_o
  );

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && res_valid_o) begin
      w.kind = kind_o; w.action = action_res_o; w.cost = cost_res_o;
      w.hash = hash_res_o; w.parent = parent_res_o; w.best = is_best_o;
      w.last = last_o; w.ovf = overflow_o;
      sb.check_word(w);
    end
  end

  // Watchdog: count cycles in which no word moves on any port
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(cand_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    func_i = it.func; action_i = it.action; cost_i = it.cost; hash_i = it.hash;
    parent_i = it.parent; finished_i = it.finished;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(it);
    if (!it.func) pushes_sent++;
  endtask

  task automatic push(logic [31:0] a, logic signed [31:0] c, logic [63:0] h,
                      logic [5:0] p, logic fin);
    cand_t it;
    it.func = 1'b0; it.action = a; it.cost = c; it.hash = h; it.parent = p;
    it.finished = fin;
    send(it);
  endtask

  task automatic flush();
    cand_t it;
    it.func = 1'b1; it.action = $urandom; it.cost = $urandom;
    it.hash = {$urandom, $urandom}; it.parent = 6'($urandom);
    it.finished = 1'($urandom);
    send(it);
  endtask

  // Hold until the beam has reported everything and any clearing pass is over
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1; cfg_index_i = idx; cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [63:0] pool[6];
    logic [63:0] h;
    logic signed [31:0] c;
    int n, r;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty flush, extremes, duplicates, table collisions
    write_reg(CFG_BEAM_WIDTH, 7'd64);
    write_reg(CFG_DEDUP, 7'd1);
    flush();
    push('1, 32'sh80000000, '1, 6'd63, 1'b1);
    push('0, 32'sh7fffffff, '0, 6'd0, 1'b1);
    push(32'h1, 32'sh7fffffff, 64'd5, 6'd1, 1'b0);
    push(32'h2, 32'sh80000000, '1, 6'd63, 1'b0);
    push(32'h3, 32'sd10, 64'd5, 6'd2, 1'b0);
    push(32'h4, 32'sd20, 64'd5, 6'd3, 1'b0);
    push(32'h5, 32'sd7, 64'd5 + 64'd1023, 6'd4, 1'b0);
    push(32'h6, 32'sd7, 64'd5 + 64'd2046, 6'd5, 1'b0);
    flush();

    // Full beam: drops, ties on worst, stale table entry after replacement
    write_reg(CFG_BEAM_WIDTH, 7'd2);
    push(32'h10, 32'sd50, 64'hA, 6'd1, 1'b0);
    push(32'h11, 32'sd50, 64'hB, 6'd2, 1'b0);
    push(32'h12, 32'sd50, 64'hC, 6'd3, 1'b0);
    push(32'h13, 32'sd40, 64'hC, 6'd4, 1'b0);
    push(32'h14, 32'sd30, 64'hA, 6'd5, 1'b0);
    push(32'h15, 32'sd45, 64'hB, 6'd6, 1'b0);
    flush();

    write_reg(CFG_DEDUP, 7'd0);
    push(32'h20, 32'sd3, 64'hD, 6'd7, 1'b0);
    push(32'h21, 32'sd3, 64'hD, 6'd8, 1'b0);
    push(32'h22, 32'sd1, 64'hD, 6'd9, 1'b0);
    flush();

    // Width lowered mid-generation keeps slots but fills sooner
    write_reg(CFG_DEDUP, 7'd1);
    write_reg(CFG_BEAM_WIDTH, 7'd127);
    push(32'h30, 32'sd9, 64'h100, 6'd1, 1'b0);
    push(32'h31, 32'sd8, 64'h101, 6'd2, 1'b0);
    push(32'h32, 32'sd7, 64'h102, 6'd3, 1'b0);
    write_reg(CFG_BEAM_WIDTH, 7'd0);
    push(32'h33, 32'sd1, 64'h103, 6'd4, 1'b0);
    push(32'h34, 32'sd8, 64'h104, 6'd5, 1'b0);
    flush();

    // Random generations
    while (pushes_sent < 280) begin
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 6);
        write_reg(CFG_BEAM_WIDTH, r == 0 ? 7'd0 : r == 1 ? 7'd1 : r == 2 ? 7'd64 :
                  r == 3 ? 7'd127 : r == 4 ? 7'($urandom_range(2, 8)) : 7'($urandom));
        write_reg(CFG_DEDUP, 7'($urandom_range(0, 3) != 0));
      end
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      no_gaps = $urandom_range(0, 3) == 0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(3, 30);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 9);
        h = r < 4 ? pool[$urandom_range(0, 5)] :
            r < 6 ? pool[0] + 64'd1023 * $urandom_range(1, 4) : {$urandom, $urandom};
        c = $urandom_range(0, 1) ? $signed($urandom_range(0, 40)) - 20 : $urandom;
        push($urandom, c, h, 6'($urandom), $urandom_range(0, 9) == 0);
      end
      if ($urandom_range(0, 7) == 0) drain();
      flush();
    end

    drain();
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
